// File: design/dfr_pkg.sv
// Shared types and constants of the DMX512 frame receiver.
package dfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 10;
    localparam int MODE_W  = 3;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 24;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_BREAK = 2'd1,
        OP_ERROR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              frame_valid;
        logic [SLOT_W-1:0] frame_slots;
        logic              timer_restart;
        logic              read_ok;
    } dfr_res_t;

endpackage

// File: design/dmx512_frame_receiver_unit.sv
// Top level of the DMX512 frame receiver.
// Usage:
//   The s channel carries one UART event per transaction: tuser holds the
//   operation (byte, break, line error, slot read), tdata the received byte
//   and the slot index to read. The m channel returns one result per event:
//   mode after the event, frame valid flag, latched slot count of the last
//   data frame, read data (zero unless a read of a written slot) and the
//   timer restart pulse.
//   Throughput is one event per cycle while m_tready stays high. A result
//   passes through the read stage (the synchronous slot store read) and
//   then the output register before it appears on the m channel.
//   Reset clears the mode, counters and frame latch at once. The slot store is
//   not swept: a high-water mark of written slots makes unwritten slots read
//   as zero, so events are accepted from the first cycle after reset.
//   When m_tready is low the output register holds its result and one more
//   event is still taken into the read stage; then s_tready drops.
module dmx512_frame_receiver_unit
    import dfr_pkg::*;
#(
    parameter int SLOT_COUNT = 513
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // rx_byte[7:0], read_slot[17:8], zero pad
    input  logic [1:0]       s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // mode[2:0], frame_valid[3], frame_slots[13:4],
                                        // read_data[21:14], timer_restart[22], zero pad
);

    localparam int AW = $clog2(SLOT_COUNT);

    logic              accept;
    dfr_res_t          res;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    logic              s1_valid_reg;
    dfr_res_t          s1_res_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_load;
    logic [BYTE_W-1:0] s1_read_data;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    dfr_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op_t'(s_tuser)),
        .rx_byte   (s_tdata[7:0]),
        .read_slot (s_tdata[17:8]),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    dfr_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s1_read_data = s1_res_reg.read_ok ? rd_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= accept;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (out_load && s1_valid_reg)
        begin
            out_data_reg <= {1'b0, s1_res_reg.timer_restart, s1_read_data,
                             s1_res_reg.frame_slots, s1_res_reg.frame_valid,
                             s1_res_reg.mode};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/dfr_slot_mem.sv
// Slot store: one write port and one registered read port.
module dfr_slot_mem
    import dfr_pkg::*;
#(
    parameter int SLOT_COUNT = 513,
    parameter int AW         = $clog2(SLOT_COUNT)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [SLOT_COUNT];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dfr_ctrl.sv
// Receive mode machine, slot counter, frame latch and slot store fill tracking.
module dfr_ctrl
    import dfr_pkg::*;
#(
    parameter int SLOT_COUNT = 513,
    parameter int AW         = $clog2(SLOT_COUNT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  op_t               op,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [SLOT_W-1:0] read_slot,
    output dfr_res_t          res,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr
);

    typedef enum logic [MODE_W-1:0] {
        M_INIT    = 3'd0,
        M_BREAK   = 3'd1,
        M_DATA    = 3'd2,
        M_ERROR   = 3'd3,
        M_UNKNOWN = 3'd4
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] lat_reg, lat_next;
    logic          latv_reg, latv_next;
    logic [AW-1:0] hw_reg, hw_next;
    logic          s0w_reg, s0w_next;
    logic [AW:0]   cnt_inc;
    logic          idx_in_range;
    logic          idx_written;

    assign cnt_inc      = {1'b0, cnt_reg} + (AW+1)'(1);
    assign idx_in_range = {1'b0, read_slot} < (SLOT_W+1)'(SLOT_COUNT);
    assign idx_written  = (read_slot == '0) ? s0w_reg : (read_slot <= SLOT_W'(hw_reg));

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        lat_next  = lat_reg;
        latv_next = latv_reg;
        hw_next   = hw_reg;
        s0w_next  = s0w_reg;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = rx_byte;
        rd_en     = 1'b0;
        rd_addr   = read_slot[AW-1:0];
        res       = '0;
        if (accept)
        begin
            unique case (op)
                OP_BYTE:
                begin
                    if (mode_reg == M_BREAK)
                    begin
                        wr_en    = 1'b1;
                        s0w_next = 1'b1;
                        cnt_next = '0;
                        if (rx_byte == '0)
                        begin
                            mode_next = M_DATA;
                        end
                        else
                        begin
                            mode_next = M_UNKNOWN;
                        end
                    end
                    else if (mode_reg == M_DATA && cnt_inc < (AW+1)'(SLOT_COUNT))
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_inc[AW-1:0];
                        cnt_next = cnt_inc[AW-1:0];
                        if (cnt_inc > {1'b0, hw_reg})
                        begin
                            hw_next = cnt_inc[AW-1:0];
                        end
                    end
                end
                OP_BREAK:
                begin
                    if (mode_reg == M_DATA)
                    begin
                        lat_next  = cnt_reg;
                        latv_next = 1'b1;
                    end
                    cnt_next          = '0;
                    mode_next         = M_BREAK;
                    res.timer_restart = 1'b1;
                end
                OP_ERROR:
                begin
                    mode_next = M_ERROR;
                end
                OP_READ:
                begin
                    rd_en       = idx_in_range;
                    res.read_ok = idx_in_range && idx_written;
                end
            endcase
        end
        res.mode        = mode_next;
        res.frame_valid = latv_next;
        res.frame_slots = SLOT_W'(lat_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_INIT;
            cnt_reg  <= '0;
            lat_reg  <= '0;
            latv_reg <= 1'b0;
            hw_reg   <= '0;
            s0w_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            lat_reg  <= lat_next;
            latv_reg <= latv_next;
            hw_reg   <= hw_next;
            s0w_reg  <= s0w_next;
        end
    end

endmodule
